// File: rtl/core/sqvs_pkg.sv
// Shared types, constants and the quarter-wave sine polynomial coefficients.
`timescale 1ns / 1ps
`default_nettype none
package sqvs_pkg;
  localparam int unsigned ANGLE_BITS = 16;
  localparam int unsigned RGBA_BITS = 32;
  localparam int unsigned TEX_BITS = 11;
  localparam int unsigned BLEND_BITS = 2;
  localparam int unsigned TRIG_BITS = 16;

  localparam logic [TEX_BITS-1:0] TEX_RESET = 11'h7FF;

  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_BR = 2'd2;
  localparam logic [1:0] CORNER_BL = 2'd3;

  localparam logic [31:0] Q30_C1 = 32'd1686629713;
  localparam logic [31:0] Q30_C3 = 32'd693598668;
  localparam logic [31:0] Q30_C5 = 32'd85569306;
  localparam logic [31:0] Q30_C7 = 32'd5026995;
  localparam logic [31:0] Q30_C9 = 32'd172272;

  // Sprite attributes that travel alongside the geometry.
  typedef struct packed {
    logic [RGBA_BITS-1:0]  rgba;
    logic [TEX_BITS-1:0]   tex;
    logic [BLEND_BITS-1:0] blend;
    logic                  fresh;
  } attr_t;
endpackage
`default_nettype wire

// File: rtl/core/sqvs_sine.sv
// Iterative Q1.15 sine/cosine unit: one Horner step per cycle on a shared multiplier.
`timescale 1ns / 1ps
`default_nettype none
module sqvs_sine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [15:0] angle,
  output logic             done,
  output logic signed [15:0] sin_q,
  output logic signed [15:0] cos_q
);
  // Step codes: 0 idle, 1 x^2, 2..5 Horner, 6 x*p, 7 round; sine then cosine.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_H1   = 3'd2;
  localparam logic [2:0] ST_H2   = 3'd3;
  localparam logic [2:0] ST_H3   = 3'd4;
  localparam logic [2:0] ST_H4   = 3'd5;
  localparam logic [2:0] ST_MUL  = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  logic [2:0]  st_r, st_nxt;
  logic        second_r;
  logic [15:0] ang_r;
  logic [1:0]  quad_r;
  logic [31:0] x_r;
  logic [31:0] x2_r;
  logic [31:0] p_r;
  logic [31:0] s_r;
  logic signed [15:0] sin_r, cos_r;
  logic        done_r;

  logic [63:0] prod;
  logic [31:0] mul_a, mul_b;
  logic [31:0] coef;
  logic [15:0] a_use;
  logic [13:0] r_raw;
  logic [14:0] r_mir;
  logic [31:0] x_w;
  logic [15:0] mag;
  logic signed [15:0] val;

  assign a_use = second_r ? ang_r + 16'd16384 : ang_r;
  assign r_raw = a_use[13:0];
  assign r_mir = a_use[14] ? 15'd16384 - {1'b0, r_raw} : {1'b0, r_raw};
  assign x_w = {1'b0, r_mir, 16'd0};

  always_comb begin
    case (st_r)
      ST_H1: coef = sqvs_pkg::Q30_C7;
      ST_H2: coef = sqvs_pkg::Q30_C5;
      ST_H3: coef = sqvs_pkg::Q30_C3;
      default: coef = sqvs_pkg::Q30_C1;
    endcase
    // The squaring step works on x straight from the angle; x^2 is then held.
    mul_a = (st_r == ST_SQ) ? x_w : (st_r == ST_MUL) ? x_r : x2_r;
    mul_b = (st_r == ST_SQ) ? x_w : p_r;
    prod = {32'd0, mul_a} * {32'd0, mul_b};
    mag = (s_r[31:15] + {16'd0, s_r[14]} > 17'd32767) ? 16'd32767
          : 16'(s_r[31:15] + {16'd0, s_r[14]});
    val = quad_r[1] ? -$signed(mag) : $signed(mag);
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: st_nxt = start ? ST_SQ : ST_IDLE;
      ST_FIN:  st_nxt = second_r ? ST_IDLE : ST_SQ;
      default: st_nxt = st_r + 3'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      second_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      done_r <= (st_r == ST_FIN) && second_r;
      if (st_r == ST_IDLE && start) second_r <= 1'b0;
      else if (st_r == ST_FIN) second_r <= ~second_r;
    end
    if (st_r == ST_IDLE && start) ang_r <= angle;
    case (st_r)
      ST_SQ: begin
        quad_r <= a_use[15:14];
        x_r <= x_w;
        x2_r <= 32'(prod >> 30);
        p_r <= sqvs_pkg::Q30_C9;
      end
      ST_H1, ST_H2, ST_H3, ST_H4: p_r <= coef - 32'(prod >> 30);
      ST_MUL: s_r <= 32'(prod >> 30);
      ST_FIN: begin
        if (second_r) cos_r <= val;
        else sin_r <= val;
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign sin_q = sin_r;
  assign cos_q = cos_r;
endmodule
`default_nettype wire

// File: rtl/core/sqvs_core_dummy_guard.sv
// Front end: holds the current texture and blend and flags the start of a new batch.
`timescale 1ns / 1ps
`default_nettype none
module sqvs_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [1:0]             cfg_blend,
  input  wire logic                   in_take,
  input  wire logic [10:0]            tex,
  input  wire logic [1:0]             blend,
  output logic                        fresh
);
  logic [10:0] cur_tex_r;
  logic [1:0]  cur_blend_r;
  assign fresh = (tex != cur_tex_r) || (blend != cur_blend_r);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_tex_r <= sqvs_pkg::TEX_RESET;
      cur_blend_r <= 2'd0;
    end else if (cfg_we) begin
      cur_blend_r <= cfg_blend;
    end else if (in_take) begin
      cur_tex_r <= tex;
      cur_blend_r <= blend;
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/sprite_quad_vertex_setup_core.sv
// Top level of the sprite quad vertex setup core.
`timescale 1ns / 1ps
`default_nettype none
// Each accepted sprite word produces four vertex words (top-left, top-right,
// bottom-right, bottom-left), the last of them marked by out_tlast. The front end
// compares texture and blend with the held state, flags a new batch and queues
// the sprite in a two-entry queue, so the input takes words back to back until
// that queue is full. The back end then evaluates sine and cosine on one shared
// iterative multiplier: seven steps for each function, then a registered done
// flag and the hand-over to emission. It then emits one vertex word per cycle
// through an output register while the receiver is ready. The back end works
// on one sprite at a time and takes the next from the queue only after the last
// vertex word of the current one; the sine unit is what limits throughput. When
// the back end is idle, a queued sprite starts the sine unit at once and its
// vertex words follow the done flag. A low out_tready stalls emission,
// the queue then fills and in_tready falls. A write to default_blend also
// reloads the held blend and should only be made while no sprite is in flight.
module sprite_quad_vertex_setup_core #(
  parameter int COORD_BITS = 20
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic [7:0] cfg_data,      // default_blend [1:0]
  input  wire logic in_tvalid,
  output logic      in_tready,
  // pos_x, pos_y, anchor_x, anchor_y, width, height, angle, rgba, tex_id, blend
  input  wire logic [8*((6*COORD_BITS+66)/8)-1:0] in_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // vert_x, vert_y, corner, vert_rgba, vert_tex, vert_blend, new_batch
  output logic [8*((2*COORD_BITS+55)/8)-1:0] out_tdata,
  output logic      out_tlast
);
  localparam int CB = COORD_BITS;
  localparam int SB = 6*CB - 2 + 16 + 32 + 11 + 2;
  localparam int OW = 8*((2*CB+55)/8);

  assign cfg_ready = 1'b1;

  logic [SB-1:0] q_r [2];
  logic          qv_r [2];
  logic          qf_r [2];
  logic          head_r, tail_r;
  logic          fresh_w;
  logic          take;
  assign take = in_tvalid && in_tready;
  assign in_tready = !(qv_r[0] && qv_r[1]);

  sqvs_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_valid), .cfg_blend(cfg_data[1:0]),
    .in_take(take), .tex(in_tdata[SB-3 -: 11]), .blend(in_tdata[SB-1 -: 2]),
    .fresh(fresh_w)
  );

  // Back end: 0 idle, 1 trig, 2 emitting.
  localparam logic [1:0] B_IDLE = 2'd0, B_TRIG = 2'd1, B_EMIT = 2'd2;
  logic [1:0] bst_r;
  logic [1:0] k_r;
  logic [SB-1:0] cur;
  logic       pop;
  logic       trig_done;
  logic signed [15:0] sn, cs;
  assign cur = q_r[head_r];

  sqvs_sine u_sine (.clk(clk), .rst_n(rst_n), .start(bst_r == B_IDLE && qv_r[head_r]),
    .angle(cur[6*CB-2 +: 16]), .done(trig_done), .sin_q(sn), .cos_q(cs));

  logic signed [CB-1:0] px, py, ax, ay;
  logic [CB-2:0] w, h;
  assign px = cur[0 +: CB];
  assign py = cur[CB +: CB];
  assign ax = cur[2*CB +: CB];
  assign ay = cur[3*CB +: CB];
  assign w  = cur[4*CB +: CB-1];
  assign h  = cur[5*CB-1 +: CB-1];

  logic signed [CB:0] cx, cy;
  logic signed [CB+17:0] rx_full, ry_full;
  logic signed [CB+1:0] rx, ry;
  logic signed [CB+2:0] vx, vy;
  logic signed [CB-1:0] sx, sy;
  localparam logic signed [CB+2:0] HI = (CB+3)'((64'sd1 <<< (CB-1)) - 1);
  localparam logic signed [CB+2:0] LO = -(CB+3)'(64'sd1 <<< (CB-1));
  always_comb begin
    cx = (k_r == sqvs_pkg::CORNER_TL || k_r == sqvs_pkg::CORNER_BL)
         ? -$signed({2'b0, w}) : $signed({2'b0, w});
    cy = (k_r[1]) ? $signed({2'b0, h}) : -$signed({2'b0, h});
    rx_full = cx * cs - cy * sn + 32768;
    ry_full = cx * sn + cy * cs + 32768;
    rx = rx_full[CB+17:16];
    ry = ry_full[CB+17:16];
    vx = px + ax + rx;
    vy = py + ay + ry;
    sx = (vx > HI) ? HI[CB-1:0] : (vx < LO) ? LO[CB-1:0] : vx[CB-1:0];
    sy = (vy > HI) ? HI[CB-1:0] : (vy < LO) ? LO[CB-1:0] : vy[CB-1:0];
  end

  logic emit;
  assign emit = (bst_r == B_EMIT) && (!out_tvalid || out_tready);
  assign pop = emit && k_r == sqvs_pkg::CORNER_BL;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv_r[0] <= 1'b0; qv_r[1] <= 1'b0;
      head_r <= 1'b0; tail_r <= 1'b0;
      bst_r <= B_IDLE; k_r <= 2'd0; out_tvalid <= 1'b0;
    end else begin
      if (take) begin
        qv_r[tail_r] <= 1'b1; tail_r <= ~tail_r;
      end
      if (pop) begin
        qv_r[head_r] <= 1'b0; head_r <= ~head_r;
      end
      case (bst_r)
        B_IDLE: if (qv_r[head_r]) bst_r <= B_TRIG;
        B_TRIG: if (trig_done) begin bst_r <= B_EMIT; k_r <= 2'd0; end
        B_EMIT: if (emit) begin
          k_r <= k_r + 2'd1;
          if (pop) bst_r <= B_IDLE;
        end
        default: bst_r <= B_IDLE;
      endcase
      if (emit) out_tvalid <= 1'b1;
      else if (out_tready) out_tvalid <= 1'b0;
    end
    if (take) begin
      q_r[tail_r] <= in_tdata[SB-1:0];
      qf_r[tail_r] <= fresh_w;
    end
    if (emit) begin
      out_tdata <= OW'({qf_r[head_r] && k_r == sqvs_pkg::CORNER_TL,
        cur[SB-1 -: 2], cur[SB-3 -: 11], cur[SB-14 -: 32], k_r, sy, sx});
      out_tlast <= (k_r == sqvs_pkg::CORNER_BL);
    end
  end
endmodule
`default_nettype wire

// File: bench/sprite_quad_vertex_setup_core_tb.sv
// Self-checking testbench for the sprite quad vertex setup core.
`timescale 1ns / 1ps
`default_nettype none
module sprite_quad_vertex_setup_core_tb;

  localparam int COORD_BITS = 20;
  localparam int IN_W = 8*((6*COORD_BITS+66)/8);
  localparam int OUT_W = 8*((2*COORD_BITS+55)/8);
  localparam int FIELDS_W = 6*COORD_BITS+59;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 60;
  localparam longint COORD_MAX = (64'sd1 <<< (COORD_BITS-1)) - 1;
  localparam longint COORD_MIN = -(64'sd1 <<< (COORD_BITS-1));

  typedef struct {
    logic signed [COORD_BITS-1:0]          pos_x, pos_y, anchor_x, anchor_y;
    logic [COORD_BITS-2:0]                 width, height;
    logic [sqvs_pkg::ANGLE_BITS-1:0]       angle;
    logic [sqvs_pkg::RGBA_BITS-1:0]        rgba;
    logic [sqvs_pkg::TEX_BITS-1:0]         tex;
    logic [sqvs_pkg::BLEND_BITS-1:0]       blend;
  } sprite_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]           x, y;
    logic [1:0]                      corner;
    logic [sqvs_pkg::RGBA_BITS-1:0]  rgba;
    logic [sqvs_pkg::TEX_BITS-1:0]   tex;
    logic [sqvs_pkg::BLEND_BITS-1:0] blend;
    logic                            new_batch, last;
  } vertex_t;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [7:0] cfg_data;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic out_tlast;

  // Copy of the block's state as the predictor sees it.
  logic [sqvs_pkg::TEX_BITS-1:0]   shadow_tex;
  logic [sqvs_pkg::BLEND_BITS-1:0] shadow_blend;

  vertex_t pending_vertices[$];
  int mismatches;
  int hold_off_cycles;
  bit ready_always;
  bit send_no_gaps;
  int idle_cycles;

  sprite_quad_vertex_setup_core #(.COORD_BITS(COORD_BITS)) u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Gap length: mostly short, now and then a long one.
  function automatic int random_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return $urandom_range(0, 2);
    if (pick < 95) return $urandom_range(3, 10);
    return $urandom_range(20, 60);
  endfunction

  // Quarter-wave polynomial sine in Q1.15, mirrored into all four quadrants.
  function automatic longint sine_q15(logic [sqvs_pkg::ANGLE_BITS-1:0] a);
    logic [1:0] quadrant;
    logic [63:0] r, x, x2, p, s;
    quadrant = a[15:14];
    r = {50'd0, a[13:0]};
    if (quadrant[0]) r = 64'd16384 - r;
    x = r << 16;
    x2 = (x * x) >> 30;
    p = {32'd0, sqvs_pkg::Q30_C9};
    p = {32'd0, sqvs_pkg::Q30_C7} - ((x2 * p) >> 30);
    p = {32'd0, sqvs_pkg::Q30_C5} - ((x2 * p) >> 30);
    p = {32'd0, sqvs_pkg::Q30_C3} - ((x2 * p) >> 30);
    p = {32'd0, sqvs_pkg::Q30_C1} - ((x2 * p) >> 30);
    s = (x * p) >> 30;
    s = (s + 64'd16384) >> 15;
    if (s > 64'd32767) s = 64'd32767;
    return quadrant[1] ? -longint'(s) : longint'(s);
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_coord(longint v);
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return v[COORD_BITS-1:0];
  endfunction

  // Works out the four corner vertices of an accepted sprite and updates the
  // batch state.
  task automatic predict_quad(sprite_t s);
    longint sn, cs, cx, cy, rx, ry, base_x, base_y;
    logic fresh;
    vertex_t v;
    sn = sine_q15(s.angle);
    cs = sine_q15(s.angle + 16'd16384);
    fresh = (s.tex != shadow_tex) || (s.blend != shadow_blend);
    shadow_tex = s.tex;
    shadow_blend = s.blend;
    base_x = longint'(s.pos_x) + longint'(s.anchor_x);
    base_y = longint'(s.pos_y) + longint'(s.anchor_y);
    for (int k = 0; k < 4; k++) begin
      // Top-left and bottom-left sit at -width, the top row at -height.
      cx = (k == 0 || k == 3) ? -longint'(s.width) : longint'(s.width);
      cy = (k < 2) ? -longint'(s.height) : longint'(s.height);
      rx = (cx * cs - cy * sn + 32768) >>> 16;
      ry = (cx * sn + cy * cs + 32768) >>> 16;
      v.x = clamp_coord(base_x + rx);
      v.y = clamp_coord(base_y + ry);
      // Corners run top-left, top-right, bottom-right, bottom-left.
      v.corner = 2'(k);
      v.rgba = s.rgba;
      v.tex = s.tex;
      v.blend = s.blend;
      v.new_batch = (k == 0) && fresh;
      v.last = (k == 3);
      pending_vertices = {pending_vertices, v};
    end
  endtask

  task automatic send_sprite(sprite_t s);
    logic [FIELDS_W-1:0] packed_fields;
    int gap;
    gap = send_no_gaps ? 0 : random_gap();
    packed_fields = {s.blend, s.tex, s.rgba, s.angle, s.height, s.width,
                     s.anchor_y, s.anchor_x, s.pos_y, s.pos_x};
    repeat (gap) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = IN_W'(packed_fields);
    do @(posedge clk); while (!in_tready);
    predict_quad(s);
  endtask

  task automatic write_default_blend(logic [sqvs_pkg::BLEND_BITS-1:0] code);
    @(negedge clk);
    in_tvalid = 1'b0;
    cfg_valid = 1'b1;
    cfg_data = {6'd0, code};
    do @(posedge clk); while (!cfg_ready);
    shadow_blend = code;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Waits for every expected vertex, then lets the pipeline settle.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic sprite_t random_sprite();
    sprite_t s;
    s.pos_x = COORD_BITS'($urandom());
    s.pos_y = COORD_BITS'($urandom());
    s.anchor_x = COORD_BITS'($urandom());
    s.anchor_y = COORD_BITS'($urandom());
    // Mostly modest coordinates so rotation shows; sometimes full range.
    if ($urandom_range(0, 3) != 0) begin
      s.pos_x = $signed(s.pos_x) >>> 3;
      s.pos_y = $signed(s.pos_y) >>> 3;
      s.anchor_x = $signed(s.anchor_x) >>> 4;
      s.anchor_y = $signed(s.anchor_y) >>> 4;
    end
    s.width = (COORD_BITS-1)'($urandom());
    s.height = (COORD_BITS-1)'($urandom());
    if ($urandom_range(0, 2) != 0) begin
      s.width = s.width >> 5;
      s.height = s.height >> 5;
    end
    s.angle = 16'($urandom());
    s.rgba = $urandom();
    // A small texture set keeps batches running; sometimes an id up to 1023 or none.
    case ($urandom_range(0, 5))
      0: s.tex = sqvs_pkg::TEX_RESET;
      1: s.tex = 11'($urandom_range(0, 1023));
      default: s.tex = 11'($urandom_range(0, 3));
    endcase
    s.blend = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : shadow_blend;
    return s;
  endfunction

  function automatic sprite_t plain_sprite(int px, int py, int w, int h, int ang,
                                           int tex, int bl);
    sprite_t s;
    s.pos_x = COORD_BITS'(px); s.pos_y = COORD_BITS'(py);
    s.anchor_x = '0; s.anchor_y = '0;
    s.width = (COORD_BITS-1)'(w); s.height = (COORD_BITS-1)'(h);
    s.angle = 16'(ang);
    s.rgba = 32'hFF80_4020; s.tex = 11'(tex); s.blend = 2'(bl);
    return s;
  endfunction

  // Extremes of every field, the four quarter turns, saturation and batching.
  task automatic test_directed();
    sprite_t s;
    // Untextured with the default blend matches the reset state: no new batch.
    send_sprite(plain_sprite(0, 0, 16, 32, 0, -1, 0));
    send_sprite(plain_sprite(160, -160, 64, 32, 16384, -1, 0));
    send_sprite(plain_sprite(160, -160, 64, 32, 32768, 5, 0));
    send_sprite(plain_sprite(160, -160, 64, 32, 49152, 5, 1));
    send_sprite(plain_sprite(-16, 16, 100, 200, 8192, 1023, 2));
    send_sprite(plain_sprite(0, 0, 524287, 524287, 65535, 1023, 3));
    send_sprite(plain_sprite(0, 0, 0, 0, 12345, 0, 3));
    // Coordinate overflow in both directions.
    s = plain_sprite(524287, 524287, 524287, 524287, 0, 0, 3);
    s.anchor_x = 20'sh7FFFF; s.anchor_y = 20'sh7FFFF;
    send_sprite(s);
    s = plain_sprite(-524288, -524288, 524287, 524287, 4096, 0, 3);
    s.anchor_x = 20'sh80000; s.anchor_y = 20'sh80000;
    s.rgba = 32'h0000_0000;
    send_sprite(s);
    s.rgba = 32'hFFFF_FFFF; s.angle = 16'hFFFF;
    send_sprite(s);
    s = plain_sprite(524287, -524288, 1, 1, 16383, 1024 - 1, 1);
    s.anchor_x = 20'sh80000; s.anchor_y = 20'sh7FFFF;
    send_sprite(s);
    send_sprite(plain_sprite(0, 0, 262144, 262144, 16385, 682, 1));
    send_sprite(plain_sprite(0, 0, 262144, 262144, 49151, 341, 2));
    wait_drained();
  endtask

  // Writing default_blend reloads the held blend, so batching follows it.
  task automatic test_config_phases();
    logic [sqvs_pkg::BLEND_BITS-1:0] codes[4] = '{2'd3, 2'd1, 2'd2, 2'd0};
    foreach (codes[i]) begin
      write_default_blend(codes[i]);
      send_sprite(plain_sprite(32, 32, 48, 48, 0, int'(shadow_tex), int'(codes[i])));
      send_sprite(plain_sprite(32, 32, 48, 48, 1000, int'(shadow_tex),
                               int'(codes[i] ^ 2'd1)));
      wait_drained();
    end
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      // Stretches without any gaps on either side.
      if (i % 60 == 0) begin
        send_no_gaps = ($urandom_range(0, 2) == 0);
        ready_always = send_no_gaps;
      end
      send_sprite(random_sprite());
      if (i == count / 2) begin
        wait_drained();
        write_default_blend(2'($urandom_range(0, 3)));
      end
    end
    send_no_gaps = 1'b0;
    ready_always = 1'b0;
    wait_drained();
  endtask

  // The receiver stops for a long stretch while sprites keep coming, so the
  // input queue fills and the block must hold off its input.
  task automatic test_output_stall();
    hold_off_cycles = 400;
    send_no_gaps = 1'b1;
    for (int i = 0; i < 10; i++) send_sprite(random_sprite());
    send_no_gaps = 1'b0;
    wait_drained();
  endtask

  // Receiver: random ready, with long hold-offs on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      out_tready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else if (ready_always) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= (random_gap() == 0) || ($urandom_range(0, 1) == 0);
    end
  end

  // Compares every vertex word that leaves the block with the oldest expectation.
  always @(posedge clk) begin
    vertex_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.x = out_tdata[19:0];
      got.y = out_tdata[39:20];
      got.corner = out_tdata[41:40];
      got.rgba = out_tdata[73:42];
      got.tex = out_tdata[84:74];
      got.blend = out_tdata[86:85];
      got.new_batch = out_tdata[87];
      got.last = out_tlast;
      if (pending_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected vertex word: corner %0d", got.corner);
      end else begin
        want = pending_vertices.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Vertex mismatch: expected x=%h y=%h c=%0d rgba=%h tex=%h bl=%0d",
                     want.x, want.y, want.corner, want.rgba, want.tex, want.blend,
                     " nb=%0d l=%0d, got x=%h y=%h c=%0d rgba=%h tex=%h bl=%0d",
                     want.new_batch, want.last, got.x, got.y, got.corner, got.rgba,
                     got.tex, got.blend, " nb=%0d l=%0d", got.new_batch, got.last);
        end
      end
    end
  end

  // Ends a run in which nothing has moved for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 8'd0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    mismatches = 0;
    hold_off_cycles = 0;
    ready_always = 1'b0;
    send_no_gaps = 1'b0;
    idle_cycles = 0;
    shadow_tex = sqvs_pkg::TEX_RESET;
    shadow_blend = 2'd0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_config_phases();
    test_output_stall();
    test_random(330);
    test_output_stall();

    if (mismatches == 0 && pending_vertices.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: sprite_quad_vertex_setup_core.f
rtl/core/sqvs_pkg.sv
rtl/core/sqvs_sine.sv
rtl/core/sqvs_core_dummy_guard.sv
rtl/core/sprite_quad_vertex_setup_core.sv
bench/sprite_quad_vertex_setup_core_tb.sv
